// ===== src/limit_order_book_matcher_unit_defines.svh =====
// ============================================================================
// Assertion macros for the order book matcher
// Shared forms of the concurrent checks used by the port checker.
// ============================================================================
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_DEFINES_SVH

// Same-cycle implication, skipped while reset is asserted.
`define LOBM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, skipped while reset is asserted.
`define LOBM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication that is also checked during reset.
`define LOBM_ASSERT_ALL(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/lobm_pkg.sv =====
// ============================================================================
// lobm_pkg
// Item types and command and status codes of the order book matcher.
// ============================================================================
package lobm_pkg;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_CANCEL = 2'd1;
    localparam logic [1:0] MODE_MODIFY = 2'd2;
    localparam logic [1:0] MODE_MATCH  = 2'd3;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_DUP       = 3'd1;
    localparam logic [2:0] STAT_NOTFOUND  = 3'd2;
    localparam logic [2:0] STAT_ZEROPRICE = 3'd3;
    localparam logic [2:0] STAT_NOMATCH   = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  order_id;
        logic        side;
        logic [7:0]  price;
        logic [30:0] quantity;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  trade_price;
        logic [30:0] trade_quantity;
    } out_item_t;

    // A command after the static checks of the front end.
    typedef struct packed {
        in_item_t item;
        logic     id_ok;
        logic     price_ok;
        logic     price_nz;
    } cmd_t;

endpackage

// ===== src/lobm_ram.sv =====
// ============================================================================
// lobm_ram
// Generic single-write, single-read memory with a registered read port.
// ============================================================================
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/lobm_front.sv =====
// ============================================================================
// lobm_front
// Command queue: takes items, applies the static range checks, and holds
// up to two classified commands for the back end.
// ============================================================================
module lobm_front #(
    parameter int MAX_ORDERS   = 256,
    parameter int PRICE_LEVELS = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  lobm_pkg::in_item_t  item,
    output logic                cmd_valid,
    input  logic                cmd_take,
    output lobm_pkg::cmd_t      cmd
);
    import lobm_pkg::*;

    cmd_t       q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       entry;
    logic       do_push;
    logic       do_take;

    always_comb
    begin
        entry.item     = item;
        entry.id_ok    = 32'(item.order_id) < MAX_ORDERS;
        entry.price_ok = 32'(item.price) < PRICE_LEVELS;
        entry.price_nz = item.price != 8'd0;
    end

    assign full      = cnt_reg == 2'd2;
    assign cmd_valid = cnt_reg != 2'd0;
    assign cmd       = q_reg[rp_reg];
    assign do_push   = push && !full;
    assign do_take   = cmd_take && cmd_valid;

    always_comb
    begin
        wp_next  = wp_reg ^ do_push;
        rp_next  = rp_reg ^ do_take;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_take};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== src/lobm_back.sv =====
// ============================================================================
// lobm_back
// Order book sequencer: order and level link memories, occupancy bits,
// best-level scan and the add, cancel, modify and match step sequences.
// ============================================================================
module lobm_back #(
    parameter int MAX_ORDERS   = 256,
    parameter int PRICE_LEVELS = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_take,
    input  lobm_pkg::cmd_t      cmd,
    input  logic                oq_full,
    output logic                res_push,
    output lobm_pkg::out_item_t res
);
    import lobm_pkg::*;

    // Ids and prices never exceed eight bits, so the tables stop at 256.
    localparam int ORD_N  = (MAX_ORDERS < 256) ? MAX_ORDERS : 256;
    localparam int LVL_N  = (PRICE_LEVELS < 256) ? PRICE_LEVELS : 256;
    localparam int IW     = $clog2(ORD_N);
    localparam int PWL    = $clog2(LVL_N);
    localparam int LAW    = PWL + 1;
    localparam int LVL_D  = 2 * (1 << PWL);
    localparam int INFO_W = 32 + PWL;
    localparam int CHUNK  = 32;
    localparam int CW     = $clog2(CHUNK);
    localparam int NCHUNK = (LVL_N + CHUNK - 1) / CHUNK;
    localparam int KW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam logic [KW-1:0] KLAST = KW'(NCHUNK - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_U0   = 4'd1;
    localparam logic [3:0] S_U1   = 4'd2;
    localparam logic [3:0] S_U2   = 4'd3;
    localparam logic [3:0] S_LK0  = 4'd4;
    localparam logic [3:0] S_LK1  = 4'd5;
    localparam logic [3:0] S_SCAN = 4'd6;
    localparam logic [3:0] S_MCHK = 4'd7;
    localparam logic [3:0] S_M0   = 4'd8;
    localparam logic [3:0] S_M1   = 4'd9;
    localparam logic [3:0] S_M2   = 4'd10;
    localparam logic [3:0] S_M3   = 4'd11;
    localparam logic [3:0] S_M4   = 4'd12;
    localparam logic [3:0] S_M5   = 4'd13;
    localparam logic [3:0] S_M6   = 4'd14;

    logic [3:0]       state_reg, state_next;
    logic [1:0]       mode_reg, mode_next;
    logic [IW-1:0]    id_reg, id_next;
    logic             side_reg, side_next;
    logic [PWL-1:0]   price_reg, price_next;
    logic [30:0]      qty_reg, qty_next;
    logic [LAW-1:0]   lv_reg, lv_next;
    logic [IW-1:0]    nx_reg, nx_next;
    logic [IW-1:0]    pv_reg, pv_next;
    logic [KW-1:0]    k_reg, k_next;
    logic             bf_reg, bf_next;
    logic             af_reg, af_next;
    logic [PWL-1:0]   bp_reg, bp_next;
    logic [PWL-1:0]   ap_reg, ap_next;
    logic [IW-1:0]    b_reg, b_next;
    logic [IW-1:0]    a_reg, a_next;
    logic [30:0]      bq_reg, bq_next;
    logic [30:0]      aq_reg, aq_next;
    logic [PWL:0]     binfo_reg, binfo_next;
    logic [PWL:0]     ainfo_reg, ainfo_next;
    logic             rm_b_reg, rm_b_next;
    logic             rm_a_reg, rm_a_next;
    logic [7:0]       tp_reg, tp_next;
    logic [30:0]      tq_reg, tq_next;
    logic [ORD_N-1:0] valid_reg, valid_next;
    logic [LVL_N-1:0] occ_buy_reg, occ_buy_next;
    logic [LVL_N-1:0] occ_sell_reg, occ_sell_next;

    logic              info_we, nxt_we, prv_we, head_we, tail_we;
    logic [IW-1:0]     info_waddr, info_raddr, nxt_waddr, nxt_raddr;
    logic [IW-1:0]     prv_waddr, prv_raddr;
    logic [LAW-1:0]    head_waddr, head_raddr, tail_waddr, tail_raddr;
    logic [INFO_W-1:0] info_wdata, info_rdata;
    logic [IW-1:0]     nxt_wdata, nxt_rdata, prv_wdata, prv_rdata;
    logic [IW-1:0]     head_wdata, head_rdata, tail_wdata, tail_rdata;

    logic                    u_side;
    logic [PWL-1:0]          u_price;
    logic [30:0]             u_qty;
    logic [LAW-1:0]          lk_lv;
    logic                    lk_occ;
    logic [IW-1:0]           c_id;
    logic [PWL-1:0]          c_price;
    logic [30:0]             m_qty;
    logic                    is_head, is_tail;
    logic [KW-1:0]           bk;
    logic [NCHUNK*CHUNK-1:0] buy_pad, sell_pad;
    logic [CHUNK-1:0]        bchunk, achunk;
    logic [CW-1:0]           hb, la;
    logic [KW+CW-1:0]        bp_cand, ap_cand;

    lobm_ram #(.WIDTH(INFO_W), .DEPTH(ORD_N)) u_info_ram (
        .clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
        .raddr(info_raddr), .rdata(info_rdata)
    );
    lobm_ram #(.WIDTH(IW), .DEPTH(ORD_N)) u_nxt_ram (
        .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
        .raddr(nxt_raddr), .rdata(nxt_rdata)
    );
    lobm_ram #(.WIDTH(IW), .DEPTH(ORD_N)) u_prv_ram (
        .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
        .raddr(prv_raddr), .rdata(prv_rdata)
    );
    lobm_ram #(.WIDTH(IW), .DEPTH(LVL_D)) u_head_ram (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );
    lobm_ram #(.WIDTH(IW), .DEPTH(LVL_D)) u_tail_ram (
        .clk(clk), .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
        .raddr(tail_raddr), .rdata(tail_rdata)
    );

    assign u_side  = info_rdata[INFO_W-1];
    assign u_price = info_rdata[INFO_W-2 -: PWL];
    assign u_qty   = info_rdata[30:0];
    assign lk_lv   = {side_reg, price_reg};
    assign lk_occ  = side_reg ? occ_sell_reg[price_reg] : occ_buy_reg[price_reg];
    assign c_id    = cmd.item.order_id[IW-1:0];
    assign c_price = cmd.item.price[PWL-1:0];
    assign m_qty   = (bq_reg < u_qty) ? bq_reg : u_qty;
    assign is_head = head_rdata == id_reg;
    assign is_tail = tail_rdata == id_reg;

    // Best-level scan: bids from the top chunk down, asks from the bottom up.
    always_comb
    begin
        buy_pad  = '0;
        sell_pad = '0;
        buy_pad[LVL_N-1:0]  = occ_buy_reg;
        sell_pad[LVL_N-1:0] = occ_sell_reg;
    end

    assign bk     = KLAST - k_reg;
    assign bchunk = buy_pad[bk*CHUNK +: CHUNK];
    assign achunk = sell_pad[k_reg*CHUNK +: CHUNK];

    always_comb
    begin
        hb = '0;
        for (int j = 0; j < CHUNK; j++)
        begin
            if (bchunk[j])
            begin
                hb = CW'(j);
            end
        end
        la = '0;
        for (int j = CHUNK - 1; j >= 0; j--)
        begin
            if (achunk[j])
            begin
                la = CW'(j);
            end
        end
    end

    assign bp_cand = {bk, hb};
    assign ap_cand = {k_reg, la};

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        id_next       = id_reg;
        side_next     = side_reg;
        price_next    = price_reg;
        qty_next      = qty_reg;
        lv_next       = lv_reg;
        nx_next       = nx_reg;
        pv_next       = pv_reg;
        k_next        = k_reg;
        bf_next       = bf_reg;
        af_next       = af_reg;
        bp_next       = bp_reg;
        ap_next       = ap_reg;
        b_next        = b_reg;
        a_next        = a_reg;
        bq_next       = bq_reg;
        aq_next       = aq_reg;
        binfo_next    = binfo_reg;
        ainfo_next    = ainfo_reg;
        rm_b_next     = rm_b_reg;
        rm_a_next     = rm_a_reg;
        tp_next       = tp_reg;
        tq_next       = tq_reg;
        valid_next    = valid_reg;
        occ_buy_next  = occ_buy_reg;
        occ_sell_next = occ_sell_reg;

        info_we    = 1'b0;
        info_waddr = id_reg;
        info_wdata = {side_reg, price_reg, qty_reg};
        info_raddr = id_reg;
        nxt_we     = 1'b0;
        nxt_waddr  = pv_reg;
        nxt_wdata  = nx_reg;
        nxt_raddr  = id_reg;
        prv_we     = 1'b0;
        prv_waddr  = nx_reg;
        prv_wdata  = pv_reg;
        prv_raddr  = id_reg;
        head_we    = 1'b0;
        head_waddr = lv_reg;
        head_wdata = nx_reg;
        head_raddr = lv_reg;
        tail_we    = 1'b0;
        tail_waddr = lv_reg;
        tail_wdata = pv_reg;
        tail_raddr = lk_lv;

        cmd_take = 1'b0;
        res_push = 1'b0;
        res      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && !oq_full)
                begin
                    cmd_take   = 1'b1;
                    mode_next  = cmd.item.mode;
                    id_next    = c_id;
                    side_next  = cmd.item.side;
                    price_next = c_price;
                    qty_next   = cmd.item.quantity;
                    case (cmd.item.mode)
                        MODE_ADD:
                        begin
                            if (!cmd.id_ok)
                            begin
                                res_push   = 1'b1;
                                res.status = STAT_NOTFOUND;
                            end
                            else if (valid_reg[c_id])
                            begin
                                res_push   = 1'b1;
                                res.status = STAT_DUP;
                            end
                            else if (!cmd.price_ok)
                            begin
                                res_push   = 1'b1;
                                res.status = STAT_ZEROPRICE;
                            end
                            else
                            begin
                                state_next = S_LK0;
                            end
                        end
                        MODE_CANCEL:
                        begin
                            if (!cmd.id_ok || !valid_reg[c_id])
                            begin
                                res_push   = 1'b1;
                                res.status = STAT_NOTFOUND;
                            end
                            else
                            begin
                                state_next = S_U0;
                            end
                        end
                        MODE_MODIFY:
                        begin
                            if (!cmd.id_ok || !valid_reg[c_id])
                            begin
                                res_push   = 1'b1;
                                res.status = STAT_NOTFOUND;
                            end
                            else if (!cmd.price_ok || !cmd.price_nz)
                            begin
                                res_push   = 1'b1;
                                res.status = STAT_ZEROPRICE;
                            end
                            else
                            begin
                                state_next = S_U0;
                            end
                        end
                        default:
                        begin
                            k_next     = '0;
                            bf_next    = 1'b0;
                            af_next    = 1'b0;
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end
            S_U0:
            begin
                state_next = S_U1;
            end
            S_U1:
            begin
                side_next  = u_side;
                lv_next    = {u_side, u_price};
                nx_next    = nxt_rdata;
                pv_next    = prv_rdata;
                head_raddr = {u_side, u_price};
                tail_raddr = {u_side, u_price};
                state_next = S_U2;
            end
            S_U2:
            begin
                if (is_head && is_tail)
                begin
                    if (lv_reg[LAW-1])
                    begin
                        occ_sell_next[lv_reg[PWL-1:0]] = 1'b0;
                    end
                    else
                    begin
                        occ_buy_next[lv_reg[PWL-1:0]] = 1'b0;
                    end
                end
                else if (is_head)
                begin
                    head_we = 1'b1;
                end
                else if (is_tail)
                begin
                    tail_we = 1'b1;
                end
                else
                begin
                    nxt_we = 1'b1;
                    prv_we = 1'b1;
                end
                if (mode_reg == MODE_MODIFY && qty_reg != 31'd0)
                begin
                    state_next = S_LK0;
                end
                else
                begin
                    valid_next[id_reg] = 1'b0;
                    if (mode_reg == MODE_MATCH && rm_a_reg)
                    begin
                        id_next    = a_reg;
                        rm_a_next  = 1'b0;
                        state_next = S_U0;
                    end
                    else
                    begin
                        res_push   = 1'b1;
                        res.status = STAT_OK;
                        if (mode_reg == MODE_MATCH)
                        begin
                            res.trade_price    = tp_reg;
                            res.trade_quantity = tq_reg;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            S_LK0:
            begin
                info_we            = 1'b1;
                valid_next[id_reg] = 1'b1;
                if (lk_occ)
                begin
                    state_next = S_LK1;
                end
                else
                begin
                    if (side_reg)
                    begin
                        occ_sell_next[price_reg] = 1'b1;
                    end
                    else
                    begin
                        occ_buy_next[price_reg] = 1'b1;
                    end
                    head_we    = 1'b1;
                    head_waddr = lk_lv;
                    head_wdata = id_reg;
                    tail_we    = 1'b1;
                    tail_waddr = lk_lv;
                    tail_wdata = id_reg;
                    res_push   = 1'b1;
                    res.status = STAT_OK;
                    state_next = S_IDLE;
                end
            end
            S_LK1:
            begin
                nxt_we     = 1'b1;
                nxt_waddr  = tail_rdata;
                nxt_wdata  = id_reg;
                prv_we     = 1'b1;
                prv_waddr  = id_reg;
                prv_wdata  = tail_rdata;
                tail_we    = 1'b1;
                tail_waddr = lk_lv;
                tail_wdata = id_reg;
                res_push   = 1'b1;
                res.status = STAT_OK;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                bf_next = bf_reg | (|bchunk);
                af_next = af_reg | (|achunk);
                if (!bf_reg && (|bchunk))
                begin
                    bp_next = bp_cand[PWL-1:0];
                end
                if (!af_reg && (|achunk))
                begin
                    ap_next = ap_cand[PWL-1:0];
                end
                if ((bf_next && af_next) || k_reg == KLAST)
                begin
                    state_next = S_MCHK;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end
            S_MCHK:
            begin
                if (!bf_reg || !af_reg || bp_reg < ap_reg)
                begin
                    res_push   = 1'b1;
                    res.status = STAT_NOMATCH;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_M0;
                end
            end
            S_M0:
            begin
                head_raddr = {1'b0, bp_reg};
                state_next = S_M1;
            end
            S_M1:
            begin
                b_next     = head_rdata;
                head_raddr = {1'b1, ap_reg};
                state_next = S_M2;
            end
            S_M2:
            begin
                a_next     = head_rdata;
                info_raddr = b_reg;
                state_next = S_M3;
            end
            S_M3:
            begin
                bq_next    = u_qty;
                binfo_next = info_rdata[INFO_W-1:31];
                info_raddr = a_reg;
                state_next = S_M4;
            end
            S_M4:
            begin
                ainfo_next = info_rdata[INFO_W-1:31];
                tq_next    = m_qty;
                tp_next    = 8'(ap_reg);
                bq_next    = bq_reg - m_qty;
                aq_next    = u_qty - m_qty;
                rm_b_next  = bq_reg == m_qty;
                rm_a_next  = u_qty == m_qty;
                state_next = S_M5;
            end
            S_M5:
            begin
                info_we    = 1'b1;
                info_waddr = b_reg;
                info_wdata = {binfo_reg, bq_reg};
                state_next = S_M6;
            end
            S_M6:
            begin
                info_we    = 1'b1;
                info_waddr = a_reg;
                info_wdata = {ainfo_reg, aq_reg};
                if (rm_b_reg)
                begin
                    id_next    = b_reg;
                    state_next = S_U0;
                end
                else if (rm_a_reg)
                begin
                    id_next    = a_reg;
                    rm_a_next  = 1'b0;
                    state_next = S_U0;
                end
                else
                begin
                    res_push           = 1'b1;
                    res.status         = STAT_OK;
                    res.trade_price    = tp_reg;
                    res.trade_quantity = tq_reg;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            occ_buy_reg  <= '0;
            occ_sell_reg <= '0;
            rm_a_reg     <= 1'b0;
            rm_b_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            occ_buy_reg  <= occ_buy_next;
            occ_sell_reg <= occ_sell_next;
            rm_a_reg     <= rm_a_next;
            rm_b_reg     <= rm_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        id_reg    <= id_next;
        side_reg  <= side_next;
        price_reg <= price_next;
        qty_reg   <= qty_next;
        lv_reg    <= lv_next;
        nx_reg    <= nx_next;
        pv_reg    <= pv_next;
        k_reg     <= k_next;
        bf_reg    <= bf_next;
        af_reg    <= af_next;
        bp_reg    <= bp_next;
        ap_reg    <= ap_next;
        b_reg     <= b_next;
        a_reg     <= a_next;
        bq_reg    <= bq_next;
        aq_reg    <= aq_next;
        binfo_reg <= binfo_next;
        ainfo_reg <= ainfo_next;
        tp_reg    <= tp_next;
        tq_reg    <= tq_next;
    end

endmodule

// ===== src/lobm_outq.sv =====
// ============================================================================
// lobm_outq
// Two-entry result queue between the sequencer and the consumer.
// ============================================================================
module lobm_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lobm_pkg::out_item_t data,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output lobm_pkg::out_item_t result
);
    import lobm_pkg::*;

    out_item_t  q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_pop;

    assign full   = cnt_reg == 2'd2;
    assign empty  = cnt_reg == 2'd0;
    assign result = q_reg[rp_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ do_pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== src/limit_order_book_matcher_unit.sv =====
// ============================================================================
// limit_order_book_matcher_unit
// Price-time priority order book with add, cancel, modify and match commands.
// ============================================================================
// Commands enter through a queue interface: an item is taken at a clock edge
// with push high and full low. Results leave the same way: the oldest result
// sits on the result port while empty is low and is taken with pop high.
// Every command gives exactly one result, in command order.
//
// A two-entry command queue decouples the producer from the sequencer, and a
// two-entry result queue decouples it from the consumer. The sequencer works
// on one command at a time, and its link memories have registered reads. The
// best-bid and best-ask scan visits one to ceil(levels/32) chunks of 32
// levels; a match with a trade then unlinks every order that the trade fills.
// A result reaches the result port through the result queue.
//
// Reset clears the queues, the order valid bits and the level occupancy bits
// at once; the link memories need no clearing. When the consumer stalls, the
// result queue fills and the sequencer stops picking up commands; the command
// queue then fills and full rises.
module limit_order_book_matcher_unit #(
    parameter int MAX_ORDERS   = 256,
    parameter int PRICE_LEVELS = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  lobm_pkg::in_item_t  cmd,
    output logic                empty,
    input  logic                pop,
    output lobm_pkg::out_item_t result
);
    import lobm_pkg::*;

    cmd_t      fe_cmd;
    logic      fe_valid;
    logic      be_take;
    logic      oq_full;
    logic      res_push;
    out_item_t res;

    // Front end: static id and price range checks, then the command queue.
    lobm_front #(.MAX_ORDERS(MAX_ORDERS), .PRICE_LEVELS(PRICE_LEVELS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(cmd),
        .cmd_valid(fe_valid), .cmd_take(be_take), .cmd(fe_cmd)
    );

    // Back end: the book itself. It only starts a command when the result
    // queue has room, so its single result can always be written.
    lobm_back #(.MAX_ORDERS(MAX_ORDERS), .PRICE_LEVELS(PRICE_LEVELS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(fe_valid), .cmd_take(be_take),
        .cmd(fe_cmd), .oq_full(oq_full), .res_push(res_push), .res(res)
    );

    lobm_outq u_outq (
        .clk(clk), .rst_n(rst_n), .push(res_push), .data(res), .full(oq_full),
        .empty(empty), .pop(pop), .result(result)
    );

endmodule

// ===== src/lobm_checker.sv =====
// ============================================================================
// lobm_checker
// Port-level checks of the order book matcher, bound to the top level.
// ============================================================================
`include "limit_order_book_matcher_unit_defines.svh"

module lobm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input lobm_pkg::out_item_t result
);
    import lobm_pkg::*;

    `LOBM_ASSERT_ALL(a_reset_clear, clk, !rst_n, empty && !full, "queues not clear in reset")

    `LOBM_ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop,
        !empty && $stable(result), "result lost while stalled")

    `LOBM_ASSERT_IMP(a_status, clk, rst_n, !empty, result.status <= STAT_NOMATCH,
        "bad status code")

    `LOBM_ASSERT_IMP(a_trade_zero, clk, rst_n, !empty && result.status != STAT_OK,
        result.trade_price == 8'd0 && result.trade_quantity == 31'd0,
        "trade fields set without a trade")

endmodule

bind limit_order_book_matcher_unit lobm_checker u_lobm_checker (
    .clk(clk), .rst_n(rst_n), .full(full), .empty(empty), .pop(pop), .result(result)
);

// ===== test/tb_limit_order_book_matcher_unit.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Order book matcher testbench
// Drives add, cancel, modify and match commands through the command queue,
// predicts every result with a behavioral order book kept in the testbench,
// and compares each result field by field in arrival order.
// ============================================================================
module tb_limit_order_book_matcher_unit;
    import lobm_pkg::*;

    localparam int NUM_IDS    = 256;
    localparam int NUM_PRICES = 256;
    localparam int CYCLE_LIMIT = 200000;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  cmd;
    logic      empty;
    logic      pop;
    out_item_t result;

    limit_order_book_matcher_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .cmd    (cmd),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // Shadow order book. Orders are indexed by id; each side and price level
    // keeps a doubly linked FIFO of ids, exactly as price-time priority needs.
    logic        book_valid [NUM_IDS];
    logic        book_side  [NUM_IDS];
    logic [7:0]  book_price [NUM_IDS];
    logic [30:0] book_qty   [NUM_IDS];
    logic [7:0]  book_next  [NUM_IDS];
    logic [7:0]  book_prev  [NUM_IDS];
    logic        lvl_busy   [2*NUM_PRICES];
    logic [7:0]  lvl_head   [2*NUM_PRICES];
    logic [7:0]  lvl_tail   [2*NUM_PRICES];

    in_item_t  pending_cmds[$];
    out_item_t expected_results[$];
    int        mismatch_count;
    int        cycle_count;
    int        idle_in;
    int        idle_out;
    logic      idle_enable;
    logic      stimulus_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int level_of(logic s, logic [7:0] p);
        return int'(s) * NUM_PRICES + int'(p);
    endfunction

    // Append an order at the tail of its level, opening the level if needed.
    function automatic void append_order(logic [7:0] id);
        int lv;
        lv = level_of(book_side[id], book_price[id]);
        if (lvl_busy[lv])
        begin
            book_next[lvl_tail[lv]] = id;
            book_prev[id] = lvl_tail[lv];
            lvl_tail[lv] = id;
        end
        else
        begin
            lvl_busy[lv] = 1'b1;
            lvl_head[lv] = id;
            lvl_tail[lv] = id;
            book_prev[id] = '0;
        end
        book_next[id] = '0;
    endfunction

    // Take an order out of its level; a level left empty is freed.
    function automatic void detach_order(logic [7:0] id);
        int   lv;
        logic at_head;
        logic at_tail;
        lv = level_of(book_side[id], book_price[id]);
        at_head = (lvl_head[lv] == id);
        at_tail = (lvl_tail[lv] == id);
        if (at_head && at_tail)
        begin
            lvl_busy[lv] = 1'b0;
            return;
        end
        if (at_head)
            lvl_head[lv] = book_next[id];
        else
            book_next[book_prev[id]] = book_next[id];
        if (at_tail)
            lvl_tail[lv] = book_prev[id];
        else
            book_prev[book_next[id]] = book_prev[id];
    endfunction

    function automatic void remove_order(logic [7:0] id);
        detach_order(id);
        book_valid[id] = 1'b0;
    endfunction

    // Apply one command to the shadow book and return the result it gives.
    function automatic out_item_t book_response(in_item_t c);
        out_item_t r;
        int bid_px;
        int ask_px;
        logic [7:0]  b;
        logic [7:0]  a;
        logic [30:0] fill;
        r = '0;
        r.status = STAT_OK;
        case (c.mode)
            MODE_ADD:
            begin
                if (book_valid[c.order_id])
                    r.status = STAT_DUP;
                else
                begin
                    book_valid[c.order_id] = 1'b1;
                    book_side[c.order_id]  = c.side;
                    book_price[c.order_id] = c.price;
                    book_qty[c.order_id]   = c.quantity;
                    append_order(c.order_id);
                end
            end
            MODE_CANCEL:
            begin
                if (!book_valid[c.order_id])
                    r.status = STAT_NOTFOUND;
                else
                    remove_order(c.order_id);
            end
            MODE_MODIFY:
            begin
                if (!book_valid[c.order_id])
                    r.status = STAT_NOTFOUND;
                else if (c.price == 8'd0)
                    r.status = STAT_ZEROPRICE;
                else
                begin
                    // The order always goes to the back of the new level,
                    // even at the same price; a zero quantity then cancels it.
                    detach_order(c.order_id);
                    book_price[c.order_id] = c.price;
                    append_order(c.order_id);
                    if (c.quantity == '0)
                        remove_order(c.order_id);
                    else
                        book_qty[c.order_id] = c.quantity;
                end
            end
            default:
            begin
                bid_px = -1;
                ask_px = -1;
                for (int p = NUM_PRICES - 1; p >= 0 && bid_px < 0; p--)
                    if (lvl_busy[level_of(1'b0, p[7:0])])
                        bid_px = p;
                for (int p = 0; p < NUM_PRICES && ask_px < 0; p++)
                    if (lvl_busy[level_of(1'b1, p[7:0])])
                        ask_px = p;
                if (bid_px < 0 || ask_px < 0 || bid_px < ask_px)
                    r.status = STAT_NOMATCH;
                else
                begin
                    b = lvl_head[level_of(1'b0, bid_px[7:0])];
                    a = lvl_head[level_of(1'b1, ask_px[7:0])];
                    fill = (book_qty[b] < book_qty[a]) ? book_qty[b] : book_qty[a];
                    r.trade_price = ask_px[7:0];
                    r.trade_quantity = fill;
                    book_qty[b] = book_qty[b] - fill;
                    book_qty[a] = book_qty[a] - fill;
                    if (book_qty[b] == '0)
                        remove_order(b);
                    if (book_qty[a] == '0)
                        remove_order(a);
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        mismatch_count++;
    endtask

    task automatic queue_cmd(logic [1:0] m, logic [7:0] id, logic s, logic [7:0] p,
                             logic [30:0] q);
        in_item_t c;
        c.mode = m;
        c.order_id = id;
        c.side = s;
        c.price = p;
        c.quantity = q;
        pending_cmds.push_back(c);
    endtask

    function automatic logic [30:0] rand_qty();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 31'h7FFFFFFF;
            2: return 31'($urandom);
            default: return 31'($urandom_range(1, 20));
        endcase
    endfunction

    // Driver: one command per accepted handshake, with random idle bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push    <= 1'b0;
            cmd     <= '0;
            idle_in <= 0;
        end
        else if (push && full)
        begin
            // Held command not yet taken; keep it on the port.
        end
        else
        begin
            if (push)
                expected_results.push_back(book_response(cmd));
            if (idle_in > 0)
            begin
                push    <= 1'b0;
                idle_in <= idle_in - 1;
            end
            else if (pending_cmds.size() > 0 && !(idle_enable && $urandom_range(0, 5) == 0))
            begin
                push <= 1'b1;
                cmd  <= pending_cmds.pop_front();
            end
            else
            begin
                push <= 1'b0;
                if (idle_enable && pending_cmds.size() > 0)
                    idle_in <= $urandom_range(0, 2);
            end
        end
    end

    // Monitor: checks each popped result against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop      <= 1'b0;
            idle_out <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", 32'(result.status), 0);
                else
                begin
                    out_item_t want;
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                        report_mismatch("status", 32'(result.status), 32'(want.status));
                    if (result.trade_price !== want.trade_price)
                        report_mismatch("trade_price", 32'(result.trade_price),
                                        32'(want.trade_price));
                    if (result.trade_quantity !== want.trade_quantity)
                        report_mismatch("trade_quantity", 32'(result.trade_quantity),
                                        32'(want.trade_quantity));
                end
            end
            if (idle_out > 0)
            begin
                pop      <= 1'b0;
                idle_out <= idle_out - 1;
            end
            else if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                pop      <= 1'b0;
                idle_out <= $urandom_range(0, 2);
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int          n;
        logic [1:0]  m;
        logic [7:0]  id;
        logic        s;
        logic [7:0]  p;
        mismatch_count = 0;
        cycle_count = 0;
        idle_enable = 1'b1;
        stimulus_done = 1'b0;
        for (int i = 0; i < NUM_IDS; i++)
            book_valid[i] = 1'b0;
        for (int i = 0; i < 2*NUM_PRICES; i++)
            lvl_busy[i] = 1'b0;
        // Reset falls a moment after time zero so that every flop sees it.
        rst_n = 1'b1;
        #1 rst_n = 1'b0;

        // Directed part: empty-book match, extremes of every field, duplicate
        // ids, unknown ids, zero-price modify, same-price modify, modify to
        // zero quantity, crossing zero-quantity heads, and a real trade.
        queue_cmd(MODE_MATCH,  8'd0,   1'b0, 8'd0,   '0);
        queue_cmd(MODE_CANCEL, 8'd7,   1'b0, 8'd0,   '0);
        queue_cmd(MODE_MODIFY, 8'd255, 1'b1, 8'd9,   31'd5);
        queue_cmd(MODE_ADD,    8'd0,   1'b0, 8'd0,   '0);
        queue_cmd(MODE_ADD,    8'd255, 1'b1, 8'd255, 31'h7FFFFFFF);
        queue_cmd(MODE_ADD,    8'd255, 1'b0, 8'd3,   31'd1);
        queue_cmd(MODE_MATCH,  8'd0,   1'b0, 8'd0,   '0);
        queue_cmd(MODE_MODIFY, 8'd255, 1'b0, 8'd0,   31'd4);
        queue_cmd(MODE_MODIFY, 8'd0,   1'b0, 8'd255, '0);
        queue_cmd(MODE_ADD,    8'd1,   1'b0, 8'd100, 31'd10);
        queue_cmd(MODE_ADD,    8'd2,   1'b0, 8'd100, 31'd20);
        queue_cmd(MODE_MODIFY, 8'd1,   1'b0, 8'd100, 31'd15);
        queue_cmd(MODE_ADD,    8'd3,   1'b1, 8'd90,  '0);
        queue_cmd(MODE_ADD,    8'd4,   1'b1, 8'd95,  31'd25);
        queue_cmd(MODE_MATCH,  8'd0,   1'b0, 8'd0,   '0);
        queue_cmd(MODE_MATCH,  8'd0,   1'b0, 8'd0,   '0);
        queue_cmd(MODE_MATCH,  8'd0,   1'b0, 8'd0,   '0);
        queue_cmd(MODE_MATCH,  8'd0,   1'b0, 8'd0,   '0);
        queue_cmd(MODE_CANCEL, 8'd255, 1'b0, 8'd0,   '0);
        queue_cmd(MODE_MATCH,  8'd0,   1'b0, 8'd0,   '0);
        queue_cmd(MODE_CANCEL, 8'd4,   1'b0, 8'd0,   '0);

        // Random part: a small id pool and a price band near the spread keep
        // orders resting, colliding and crossing; wide values add noise.
        n = 0;
        while (n < 500)
        begin
            m  = 2'($urandom_range(0, 3));
            id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23));
            s  = 1'($urandom);
            p  = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                 : 8'($urandom_range(120, 135));
            if ($urandom_range(0, 19) == 0)
                p = '0;
            queue_cmd(m, id, s, p, rand_qty());
            n++;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Run the tail of the stimulus with no idling on either side.
        wait (pending_cmds.size() < 60);
        idle_enable = 1'b0;
        wait (pending_cmds.size() == 0);
        @(posedge clk);
        while (push)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
